// ===== hw/rtl/fra_pkg.sv =====
// fra_pkg: shared widths, codes and constants of the frame ring allocator.
// Used by the channel interfaces, the limit-remainder unit, the top level
// and the checker. No dependencies.
package fra_pkg;

	// field widths
	localparam int OFFSET_W  = 21;
	localparam int SIZE_W    = 21;
	localparam int SLOT_W    = 4;
	localparam int ADDR_W    = 64;
	localparam int RB_W      = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	// ring geometry; ALIGN_BYTES must stay a power of two
	localparam int FRAME_SLOTS_DEF   = 3;
	localparam int ALIGN_BYTES       = 256;
	localparam int ALIGN_BITS        = $clog2(ALIGN_BYTES);
	localparam int OFFSET_LIMIT      = 2097151;
	// 20 blocks = 10*2<<8 bytes
	localparam int RING_BLOCKS_RESET = 20;

	// largest ring in whole blocks, and the bytes of the offset limit past it
	localparam int LIMIT_BLOCKS = OFFSET_LIMIT / ALIGN_BYTES;
	localparam int RING_CAP     = LIMIT_BLOCKS * ALIGN_BYTES;
	localparam int LIMIT_TAIL   = OFFSET_LIMIT % ALIGN_BYTES;
	localparam int LIMIT_BLK_W  = $clog2(LIMIT_BLOCKS + 1);

	// offset limit reduced modulo the ring size after reset
	localparam int LIM_MOD_RESET =
		(LIMIT_BLOCKS % RING_BLOCKS_RESET) * ALIGN_BYTES + LIMIT_TAIL;

	typedef enum logic {
		OP_ALLOC       = 1'b0,
		OP_BEGIN_FRAME = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RING_BLOCKS = 2'd0,
		CFG_GPU_BASE    = 2'd1,
		CFG_CPU_BASE    = 2'd2
	} cfg_reg_t;

	// status of the limit-remainder unit
	typedef struct packed {
		logic                busy;
		logic [OFFSET_W-1:0] lim_mod;
	} lim_status_t;

endpackage

// ===== hw/rtl/fra_req_if.sv =====
// fra_req_if: request channel (allocate or begin frame) with valid/ready.
// Depends on fra_pkg.
interface fra_req_if import fra_pkg::*; ();
	logic              valid;
	logic              ready;
	op_t               opcode;
	logic [SIZE_W-1:0] alloc_size;
	logic [SLOT_W-1:0] frame_slot;

	modport source (output valid, opcode, alloc_size, frame_slot, input ready);
	modport sink   (input valid, opcode, alloc_size, frame_slot, output ready);
endinterface

// ===== hw/rtl/fra_rsp_if.sv =====
// fra_rsp_if: result channel (addresses and out-of-memory flag) with valid/ready.
// Depends on fra_pkg.
interface fra_rsp_if import fra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] gpu_address;
	logic [ADDR_W-1:0] cpu_address;
	logic              out_of_memory;

	modport source (output valid, gpu_address, cpu_address, out_of_memory,
		input ready);
	modport sink   (input valid, gpu_address, cpu_address, out_of_memory,
		output ready);
endinterface

// ===== hw/rtl/fra_limit_mod.sv =====
// fra_limit_mod: bit-serial remainder of the offset limit by the ring size,
// one quotient bit per cycle, restarted on every ring size write.
// Depends on fra_pkg.
module fra_limit_mod import fra_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RB_W-1:0] ring_blocks,
	output lim_status_t     status
);

	localparam int CNT_W = $clog2(LIMIT_BLK_W);
	localparam logic [LIMIT_BLK_W-1:0] DIVIDEND = LIMIT_BLK_W'(LIMIT_BLOCKS);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RB_W-1:0]     rem_q;
	logic [OFFSET_W-1:0] lim_q;

	logic [RB_W:0]       step;
	logic [RB_W-1:0]     rem_n;
	logic [OFFSET_W-1:0] lim_n;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		step = {rem_q, DIVIDEND[cnt_q]};
		if (step >= {1'b0, ring_blocks}) begin
			rem_n = RB_W'(step - {1'b0, ring_blocks});
		end else begin
			rem_n = RB_W'(step);
		end
		if (ring_blocks == '0) begin
			lim_n = '0;
		end else begin
			lim_n = (OFFSET_W'(rem_n) << ALIGN_BITS) + OFFSET_W'(LIMIT_TAIL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			lim_q  <= OFFSET_W'(LIM_MOD_RESET);
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(LIMIT_BLK_W - 1);
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				lim_q  <= lim_n;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign status.busy    = busy_q;
	assign status.lim_mod = lim_q;

endmodule

// ===== hw/rtl/frame_ring_allocator_top.sv =====
// Frame ring allocator top; depends on fra_pkg, fra_req_if, fra_rsp_if and fra_limit_mod.
// A request is registered, processed in one pass and its result registered: the result
// word is offered from the result register, and one request is taken per cycle while the
// result side keeps up. A stalled result word holds; the input stage waits behind it.
// After a ring_blocks write, requests are held off while the remainder (one bit a cycle) is rebuilt.
// Reset clears head, tail, frame counts and current frame and loads a ring of 20 blocks.
module frame_ring_allocator_top import fra_pkg::*; #(
	parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	fra_req_if.sink              req,
	fra_rsp_if.source            rsp
);

	localparam int IDX_W = $clog2(FRAME_SLOTS);
	localparam int SZ_W  = OFFSET_W + 1;
	localparam int CH_W  = OFFSET_W + 2;
	localparam int TOT_W = RB_W + ALIGN_BITS;

	// configuration
	logic [RB_W-1:0]   ring_blocks_q;
	logic [ADDR_W-1:0] gpu_base_q;
	logic [ADDR_W-1:0] cpu_base_q;
	logic              ring_wr;

	// allocator state; fbm_q keeps each frame count reduced modulo the ring
	logic [OFFSET_W-1:0] head_q;
	logic [OFFSET_W-1:0] tail_q;
	logic [OFFSET_W-1:0] fb_q  [FRAME_SLOTS];
	logic [OFFSET_W-1:0] fbm_q [FRAME_SLOTS];
	logic [IDX_W-1:0]    cur_q;

	// input stage
	logic              valid_s1;
	op_t               op_s1;
	logic [SIZE_W-1:0] size_s1;
	logic [SLOT_W-1:0] slot_s1;

	// result register
	logic              rsp_valid_q;
	logic [ADDR_W-1:0] gpu_q;
	logic [ADDR_W-1:0] cpu_q;
	logic              oom_q;

	lim_status_t lim;
	logic        advance;

	assign ring_wr = cfg_we && (cfg_index == CFG_RING_BLOCKS);

	fra_limit_mod u_limit_mod (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (ring_wr),
		.ring_blocks (ring_blocks_q),
		.status      (lim)
	);

	// handshake
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !lim.busy && (!valid_s1 || advance);

	// ring size in bytes, capped to whole blocks below the offset limit
	logic [TOT_W-1:0]    total_full;
	logic [OFFSET_W-1:0] total;

	always_comb begin
		total_full = TOT_W'(ring_blocks_q) << ALIGN_BITS;
		if (total_full > TOT_W'(RING_CAP)) begin
			total = OFFSET_W'(RING_CAP);
		end else begin
			total = OFFSET_W'(total_full);
		end
	end

	// single pass over the registered request
	logic              slot_ok;
	logic [IDX_W-1:0]  rd_idx;
	logic [OFFSET_W-1:0] fb_rd;
	logic [OFFSET_W-1:0] fbm_rd;
	logic [SZ_W-1:0]   sz_up;
	logic [OFFSET_W-1:0] h_eff;
	logic [OFFSET_W-1:0] t_eff;
	logic [OFFSET_W-1:0] free_sp;
	logic [OFFSET_W-1:0] room;
	logic [OFFSET_W-1:0] pad;
	logic              oom;
	logic [SZ_W-1:0]   head_sum;
	logic [OFFSET_W-1:0] head_new;
	logic [CH_W-1:0]   charged;
	logic [CH_W-1:0]   msum;
	logic [CH_W-1:0]   m1;
	logic [CH_W-1:0]   m2;
	logic              sat;
	logic [OFFSET_W-1:0] fb_new;
	logic [OFFSET_W-1:0] fbm_new;
	logic [SZ_W-1:0]   bt;
	logic [OFFSET_W-1:0] tail_rel;

	always_comb begin
		slot_ok = SZ_W'(slot_s1) < SZ_W'(FRAME_SLOTS);
		if (op_s1 == OP_BEGIN_FRAME) begin
			rd_idx = slot_ok ? IDX_W'(slot_s1) : '0;
		end else begin
			rd_idx = cur_q;
		end
		fb_rd  = fb_q[rd_idx];
		fbm_rd = fbm_q[rd_idx];

		// round up to whole blocks
		sz_up = ((SZ_W'(size_s1) + SZ_W'(ALIGN_BYTES - 1)) >> ALIGN_BITS) << ALIGN_BITS;

		// room at the head, wrapping past the ring end when it is short
		pad   = '0;
		h_eff = head_q;
		t_eff = tail_q;
		room  = (head_q < total) ? total - head_q : '0;
		if (tail_q > head_q) begin
			free_sp = tail_q - head_q;
		end else if (tail_q < head_q) begin
			if (SZ_W'(room) < sz_up) begin
				pad     = room;
				h_eff   = '0;
				free_sp = tail_q;
			end else begin
				free_sp = room;
			end
		end else begin
			h_eff   = '0;
			t_eff   = '0;
			free_sp = total;
		end
		oom = sz_up > SZ_W'(free_sp);

		head_sum = SZ_W'(h_eff) + sz_up;
		if (head_sum >= SZ_W'(total)) begin
			head_new = OFFSET_W'(head_sum - SZ_W'(total));
		end else begin
			head_new = OFFSET_W'(head_sum);
		end

		// frame charge, saturating; reduced copy needs two subtracts at most
		charged = CH_W'(fb_rd) + CH_W'(pad) + CH_W'(sz_up);
		sat     = charged > CH_W'(OFFSET_LIMIT);
		msum    = CH_W'(fbm_rd) + CH_W'(pad) + CH_W'(sz_up);
		m1      = (msum >= CH_W'(total)) ? msum - CH_W'(total) : msum;
		m2      = (m1 >= CH_W'(total)) ? m1 - CH_W'(total) : m1;
		fb_new  = sat ? OFFSET_W'(OFFSET_LIMIT) : OFFSET_W'(charged);
		fbm_new = sat ? lim.lim_mod : OFFSET_W'(m2);

		// tail after releasing a frame
		bt = SZ_W'(tail_q) + SZ_W'(fbm_rd);
		if (total == '0) begin
			tail_rel = '0;
		end else if (bt >= SZ_W'(total)) begin
			tail_rel = OFFSET_W'(bt - SZ_W'(total));
		end else begin
			tail_rel = OFFSET_W'(bt);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_blocks_q <= RB_W'(RING_BLOCKS_RESET);
			gpu_base_q    <= '0;
			cpu_base_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RING_BLOCKS: ring_blocks_q <= cfg_wdata[RB_W-1:0];
				CFG_GPU_BASE:    gpu_base_q    <= cfg_wdata;
				CFG_CPU_BASE:    cpu_base_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cur_q  <= '0;
			for (int i = 0; i < FRAME_SLOTS; i++) begin
				fb_q[i]  <= '0;
				fbm_q[i] <= '0;
			end
		end else if (ring_wr) begin
			head_q <= '0;
			tail_q <= '0;
			for (int i = 0; i < FRAME_SLOTS; i++) begin
				fb_q[i]  <= '0;
				fbm_q[i] <= '0;
			end
		end else if (advance) begin
			if (op_s1 == OP_BEGIN_FRAME) begin
				if (slot_ok) begin
					cur_q         <= rd_idx;
					tail_q        <= tail_rel;
					fb_q[rd_idx]  <= '0;
					fbm_q[rd_idx] <= '0;
				end
			end else if (!oom) begin
				head_q        <= head_new;
				tail_q        <= t_eff;
				fb_q[rd_idx]  <= fb_new;
				fbm_q[rd_idx] <= fbm_new;
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.opcode;
			size_s1 <= req.alloc_size;
			slot_s1 <= req.frame_slot;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (op_s1 == OP_BEGIN_FRAME || oom) begin
				gpu_q <= '0;
				cpu_q <= '0;
			end else begin
				gpu_q <= gpu_base_q + ADDR_W'(h_eff);
				cpu_q <= cpu_base_q + ADDR_W'(h_eff);
			end
			oom_q <= (op_s1 == OP_ALLOC) && oom;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.gpu_address   = gpu_q;
	assign rsp.cpu_address   = cpu_q;
	assign rsp.out_of_memory = oom_q;

endmodule

// ===== hw/rtl/fra_checker.sv =====
// fra_checker: port-level assertions for the frame ring allocator, bound to
// the top level. Depends on fra_pkg and frame_ring_allocator_top.
module fra_checker import fra_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [ADDR_W-1:0]    gpu_address,
	input logic [ADDR_W-1:0]    cpu_address,
	input logic                 out_of_memory
);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(gpu_address) &&
			$stable(cpu_address) && $stable(out_of_memory))
		else $error("stalled result word changed");

	// a failed allocation returns no address
	a_oom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && out_of_memory |-> gpu_address == '0 && cpu_address == '0)
		else $error("out of memory result carries an address");

	// a result after an idle output comes from a request taken through the input stage
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result appeared without a matching request");

	// a ring size write holds off requests while the limit is recomputed
	a_ring_wr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == CFG_RING_BLOCKS |=> !req_ready)
		else $error("request taken right after ring size write");

endmodule

bind frame_ring_allocator_top fra_checker u_fra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.gpu_address   (rsp.gpu_address),
	.cpu_address   (rsp.cpu_address),
	.out_of_memory (rsp.out_of_memory)
);

// ===== verif/tb_frame_ring_allocator_top.sv =====
// tb_frame_ring_allocator_top: self-checking bench for the frame ring allocator.
// Predicts every result word from its own ring model and compares field by field.
// Depends on fra_pkg, fra_req_if, fra_rsp_if and frame_ring_allocator_top.
module tb_frame_ring_allocator_top import fra_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOTS = FRAME_SLOTS_DEF;
	// index past the register list; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int unsigned SIZE_MAX = (1 << SIZE_W) - 1;

	typedef struct packed {
		op_t               opcode;
		logic [SIZE_W-1:0] alloc_size;
		logic [SLOT_W-1:0] frame_slot;
	} req_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] gpu_address;
		logic [ADDR_W-1:0] cpu_address;
		logic              out_of_memory;
	} rsp_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	fra_req_if req_ch ();
	fra_rsp_if rsp_ch ();

	frame_ring_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #4 clk = ~clk;

	// ring model: settings and state as the block should hold them
	logic [RB_W-1:0]     ring_blocks_m;
	logic [ADDR_W-1:0]   gpu_base_m;
	logic [ADDR_W-1:0]   cpu_base_m;
	logic [OFFSET_W-1:0] head_q;
	logic [OFFSET_W-1:0] tail_q;
	logic [OFFSET_W-1:0] slot_bytes [NSLOTS];
	logic [SLOT_W-1:0]   cur_frame;

	req_word_t pending_words [$];
	rsp_word_t due_words [$];
	int        issued = 0;
	int        returned = 0;
	int        err_cnt = 0;
	bit        no_idle = 1'b0;

	// ring size in bytes, capped at the largest block multiple below the offset limit
	function automatic longint unsigned ring_span();
		longint unsigned total;
		total = 64'(ring_blocks_m);
		total = total * ALIGN_BYTES;
		if (total > 64'(RING_CAP))
			total = 64'(RING_CAP);
		return total;
	endfunction

	// apply one request to the ring model and return the word it produces
	function automatic rsp_word_t ring_advance(req_word_t w);
		rsp_word_t       r;
		longint unsigned total, size, head, tail, room, pad, charged;
		r = '0;
		total = ring_span();
		if (w.opcode == OP_BEGIN_FRAME) begin
			// slots past the last frame are dropped
			if (w.frame_slot < NSLOTS) begin
				cur_frame = w.frame_slot;
				charged = 64'(tail_q);
				charged = charged + 64'(slot_bytes[w.frame_slot]);
				slot_bytes[w.frame_slot] = '0;
				tail_q = (total != 0) ? OFFSET_W'(charged % total) : '0;
			end
		end else begin
			size = 64'(w.alloc_size);
			size = (size + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
			head = 64'(head_q);
			tail = 64'(tail_q);
			pad = 0;
			if (tail > head) begin
				room = tail - head;
			end else if (tail < head) begin
				room = (head < total) ? total - head : 0;
				// end of ring too short: skip to zero, padding goes to this frame
				if (room < size) begin
					pad = room;
					head = 0;
					room = tail;
				end
			end else begin
				// head on tail reads as empty
				head = 0;
				tail = 0;
				room = total;
			end
			if (size > room) begin
				r.out_of_memory = 1'b1;
			end else begin
				r.gpu_address = gpu_base_m + head;
				r.cpu_address = cpu_base_m + head;
				head = head + size;
				if (head >= total)
					head = head - total;
				head_q = OFFSET_W'(head);
				tail_q = OFFSET_W'(tail);
				charged = 64'(slot_bytes[cur_frame]);
				charged = charged + pad + size;
				if (charged > OFFSET_LIMIT)
					charged = OFFSET_LIMIT;
				slot_bytes[cur_frame] = OFFSET_W'(charged);
			end
		end
		return r;
	endfunction

	function automatic req_word_t alloc_word(int unsigned size);
		req_word_t w;
		w.opcode = OP_ALLOC;
		w.alloc_size = SIZE_W'(size);
		w.frame_slot = SLOT_W'($urandom);
		return w;
	endfunction

	function automatic req_word_t frame_word(int unsigned slot);
		req_word_t w;
		w.opcode = OP_BEGIN_FRAME;
		w.alloc_size = SIZE_W'($urandom);
		w.frame_slot = SLOT_W'(slot);
		return w;
	endfunction

	task automatic queue_word(req_word_t w);
		pending_words.push_back(w);
		issued++;
	endtask

	// hold the sender until every word in flight has come back
	task automatic drain();
		while (returned != issued)
			@(posedge clk);
	endtask

	// register write; the model follows the same write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RING_BLOCKS: begin
				ring_blocks_m = data[RB_W-1:0];
				head_q = '0;
				tail_q = '0;
				for (int i = 0; i < NSLOTS; i++)
					slot_bytes[i] = '0;
				// limit-remainder unit is busy for a while after this write
				repeat (16) @(posedge clk);
			end
			CFG_GPU_BASE: gpu_base_m = data;
			CFG_CPU_BASE: cpu_base_m = data;
			default: ;
		endcase
	endtask

	// sender: one word per handshake, random gap drawn per word
	req_word_t cur_req;
	int        gap_left = 0;

	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			due_words.push_back(ring_advance(cur_req));
		if (!req_ch.valid || req_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				cur_req = pending_words.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.opcode <= cur_req.opcode;
				req_ch.alloc_size <= cur_req.alloc_size;
				req_ch.frame_slot <= cur_req.frame_slot;
				gap_left = no_idle ? 0 : $urandom_range(0, 6);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: check each word against the oldest prediction, random stalls
	rsp_word_t exp_w;
	int        stall_left = 0;

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (due_words.size() == 0) begin
				$error("unexpected result word: gpu_address %h cpu_address %h out_of_memory %b",
					rsp_ch.gpu_address, rsp_ch.cpu_address, rsp_ch.out_of_memory);
				err_cnt++;
			end else begin
				exp_w = due_words.pop_front();
				returned++;
				if (rsp_ch.gpu_address !== exp_w.gpu_address) begin
					$error("gpu_address: expected %h, got %h",
						exp_w.gpu_address, rsp_ch.gpu_address);
					err_cnt++;
				end
				if (rsp_ch.cpu_address !== exp_w.cpu_address) begin
					$error("cpu_address: expected %h, got %h",
						exp_w.cpu_address, rsp_ch.cpu_address);
					err_cnt++;
				end
				if (rsp_ch.out_of_memory !== exp_w.out_of_memory) begin
					$error("out_of_memory: expected %b, got %b",
						exp_w.out_of_memory, rsp_ch.out_of_memory);
					err_cnt++;
				end
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 6);
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// stimulus
	initial begin
		int unsigned     rb, size, slot, pick, next_slot, sent, span;
		logic [CFG_W-1:0] d;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ALLOC;
		req_ch.alloc_size = '0;
		req_ch.frame_slot = '0;
		rsp_ch.ready = 1'b0;

		ring_blocks_m = RB_W'(RING_BLOCKS_RESET);
		gpu_base_m = '0;
		cpu_base_m = '0;
		head_q = '0;
		tail_q = '0;
		for (int i = 0; i < NSLOTS; i++)
			slot_bytes[i] = '0;
		cur_frame = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the reset ring: alignment, oversize, dropped slots, wrap with padding,
		// full ring, head on tail restart
		queue_word(alloc_word(0));
		queue_word(alloc_word(SIZE_MAX));
		queue_word(alloc_word(1048576));
		queue_word(frame_word(15));
		queue_word(frame_word(NSLOTS));
		queue_word(alloc_word(1));
		queue_word(alloc_word(255));
		queue_word(alloc_word(257));
		queue_word(alloc_word(2048));
		queue_word(frame_word(1));
		queue_word(alloc_word(1024));
		queue_word(frame_word(0));
		queue_word(alloc_word(2048));
		queue_word(alloc_word(2048));
		queue_word(alloc_word(1024));
		queue_word(alloc_word(256));
		queue_word(frame_word(2));
		drain();

		// largest ring, bases that wrap, frame count saturation, unaligned tail
		write_reg(CFG_RING_BLOCKS, '1);
		write_reg(CFG_GPU_BASE, '1);
		write_reg(CFG_CPU_BASE, 64'h8000_0000_0000_0000);
		write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
		queue_word(alloc_word(1048576));
		queue_word(alloc_word(1048320));
		queue_word(alloc_word(256));
		queue_word(alloc_word(SIZE_MAX));
		queue_word(frame_word(2));
		drain();

		// empty ring: only zero-size requests fit
		write_reg(CFG_RING_BLOCKS, 64'hABCD_0000_0000_0000);
		queue_word(alloc_word(0));
		queue_word(alloc_word(1));
		queue_word(frame_word(0));
		queue_word(alloc_word(0));
		drain();

		// random phases, each with its own settings
		next_slot = 0;
		for (int p = 0; p < 10; p++) begin
			no_idle = (p % 4 == 3);
			case (p % 8)
				0: rb = RING_BLOCKS_RESET;
				1: rb = 1;
				2: rb = (1 << RB_W) - 1;
				3: rb = $urandom_range(2, 12);
				4: rb = 4096;
				5: rb = 0;
				6: rb = $urandom_range(1, (1 << RB_W) - 1);
				default: rb = $urandom_range(2, 40);
			endcase
			if (p % 3 != 1) begin
				d = {$urandom, $urandom};
				d[RB_W-1:0] = RB_W'(rb);
				write_reg(CFG_RING_BLOCKS, d);
			end
			write_reg(CFG_GPU_BASE, (p % 5 == 0) ? '1 : {$urandom, $urandom});
			write_reg(CFG_CPU_BASE, (p % 5 == 2) ? '0 : {$urandom, $urandom});
			if (p % 4 == 2)
				write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});

			span = 32'(ring_span());
			if (span < ALIGN_BYTES)
				span = ALIGN_BYTES;
			sent = 0;
			while (sent < 120) begin
				if (p == 4 && sent == 60)
					drain();
				pick = $urandom_range(0, 99);
				if (pick < 18) begin
					// frames rotate through the slots in order
					queue_word(frame_word(next_slot));
					next_slot = (next_slot + 1) % NSLOTS;
					sent++;
				end else if (pick < 23) begin
					slot = $urandom_range(0, 15);
					queue_word(frame_word(slot));
					if (slot < NSLOTS)
						sent++;
				end else begin
					if (pick < 73)
						size = $urandom_range(0, span / 3);
					else if (pick < 84)
						size = ALIGN_BYTES * $urandom_range(0, span / ALIGN_BYTES);
					else if (pick < 93)
						size = $urandom_range(0, SIZE_MAX);
					else
						size = $urandom_range(0, 2 * ALIGN_BYTES);
					queue_word(alloc_word(size));
					sent++;
				end
			end
			drain();
		end

		no_idle = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/fra_pkg.sv
hw/rtl/fra_req_if.sv
hw/rtl/fra_rsp_if.sv
hw/rtl/fra_limit_mod.sv
hw/rtl/frame_ring_allocator_top.sv
hw/rtl/fra_checker.sv
verif/tb_frame_ring_allocator_top.sv
